>>> design/cpp_pkg.sv
package cpp_pkg;

  // Character store geometry
  localparam int FONT_CHARS     = 512;
  localparam int USER_CHARS     = 256;
  localparam int BYTES_PER_CHAR = 24;
  localparam int PLANES         = 3;
  localparam int PLANE_ROWS     = BYTES_PER_CHAR / PLANES;
  localparam int TOTAL_CHARS    = FONT_CHARS + USER_CHARS;

  localparam int ROW_W     = 3;
  localparam int CHAR_W    = 10;
  localparam int SEL_W     = 8;
  localparam int RAM_DEPTH = TOTAL_CHARS * PLANE_ROWS;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // Bus pages and the decoded window
  localparam logic [7:0]  PAGE_FONT  = 8'h14;
  localparam logic [7:0]  PAGE_BLUE  = 8'h15;
  localparam logic [7:0]  PAGE_RED   = 8'h16;
  localparam logic [7:0]  PAGE_GREEN = 8'h17;
  localparam logic [15:0] WIN_LO     = 16'h1400;
  localparam logic [15:0] WIN_HI     = 16'h17FF;
  localparam logic [7:0]  OFF_PAGE_DATA = 8'hFF;

  // Plane numbers, as used by the byte load
  localparam logic [1:0] PL_RED   = 2'd0;
  localparam logic [1:0] PL_GREEN = 2'd1;
  localparam logic [1:0] PL_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    FN_READ      = 3'd0,
    FN_WRITE     = 3'd1,
    FN_SELECT    = 3'd2,
    FN_LOAD_BYTE = 3'd3,
    FN_LOAD_ROW  = 3'd4
  } func_t;

  // Where the read data of a request comes from
  typedef enum logic [2:0] {
    RS_ZERO,
    RS_OFF_PAGE,
    RS_RED,
    RS_GREEN,
    RS_BLUE
  } rd_src_t;

endpackage

>>> design/cpp_ram.sv
module cpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6144
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port; read data is registered and holds while the port is idle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> design/char_pattern_port.sv
// Channel   Dir  tdata (low bit up)                              tuser
// s_axis    in   address 16, data_byte 8, load_char 10,          func 3
//                load_plane 2, load_row 3, one zero pad bit
// m_axis    out  read_data 8                                     in_window 1
//
// One request is accepted per cycle while the port is not stalled; its result
// passes through the pattern memory read and then the output register.
// Reset is synchronous. After reset a clearing pass writes zero through all
// 6144 rows of the pattern memory, with s_axis_tready low.
// A stalled output holds the pending request in the read stage, and the input
// stalls only during the clearing pass or while the read stage is full and the output is stalled.
module char_pattern_port
  import cpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // address, data_byte, load_char, load_plane, load_row
  input  logic [2:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // read_data
  output logic        m_axis_tuser    // in_window
);

  // Request fields.
  logic [15:0]       address;
  logic [7:0]        data_byte;
  logic [CHAR_W-1:0] load_char;
  logic [1:0]        load_plane;
  logic [ROW_W-1:0]  load_row;
  func_t             func;
  logic [7:0]        page;

  assign address    = s_axis_tdata[15:0];
  assign data_byte  = s_axis_tdata[23:16];
  assign load_char  = s_axis_tdata[33:24];
  assign load_plane = s_axis_tdata[35:34];
  assign load_row   = s_axis_tdata[38:36];
  assign func       = func_t'(s_axis_tuser);
  assign page       = address[15:8];

  // Architectural state. The plane row indices are kept by plane number.
  logic [SEL_W-1:0] sel_char, sel_char_next;
  logic [ROW_W-1:0] font_idx, font_idx_next;
  logic [ROW_W-1:0] plane_idx [PLANES];
  logic [ROW_W-1:0] plane_idx_next [PLANES];

  // Clearing pass after reset.
  logic              clr_active;
  logic [RAM_AW-1:0] clr_addr;

  // Pipeline control.
  logic    accept;
  logic    out_free;
  logic    s1_valid;
  rd_src_t s1_src;
  logic    s1_win;
  rd_src_t rd_src;
  logic    win;

  // Pattern memory: one RAM per plane, addressed by character and row, so a
  // row load writes all three planes in the same cycle.
  logic              ram_en    [PLANES];
  logic              ram_we    [PLANES];
  logic [RAM_AW-1:0] ram_addr  [PLANES];
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_q     [PLANES];

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !clr_active && (!s1_valid || out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign win           = (address >= WIN_LO) && (address <= WIN_HI);

  always_comb begin
    logic [CHAR_W-1:0] user_char;
    logic [CHAR_W-1:0] font_char;
    logic              page_is_plane;
    logic [1:0]        page_plane;
    logic              load_ok;

    user_char = CHAR_W'(FONT_CHARS) + CHAR_W'(sel_char);
    font_char = CHAR_W'(sel_char);
    load_ok   = (load_char < CHAR_W'(TOTAL_CHARS));

    page_is_plane = 1'b1;
    page_plane    = PL_RED;
    case (page)
      PAGE_BLUE:  page_plane = PL_BLUE;
      PAGE_RED:   page_plane = PL_RED;
      PAGE_GREEN: page_plane = PL_GREEN;
      default:    page_is_plane = 1'b0;
    endcase

    sel_char_next = sel_char;
    font_idx_next = font_idx;
    for (int p = 0; p < PLANES; p++) begin
      plane_idx_next[p] = plane_idx[p];
      ram_en[p]         = 1'b0;
      ram_we[p]         = 1'b0;
      ram_addr[p]       = RAM_AW'({user_char, plane_idx[p]});
    end
    ram_wdata = data_byte;
    rd_src    = RS_ZERO;

    if (clr_active) begin
      ram_wdata = '0;
      for (int p = 0; p < PLANES; p++) begin
        ram_en[p]   = 1'b1;
        ram_we[p]   = 1'b1;
        ram_addr[p] = clr_addr;
      end
    end else if (accept) begin
      unique case (func)
        FN_READ: begin
          if (page == PAGE_FONT) begin
            // Font bytes sit in the red plane of the low character slots.
            ram_en[PL_RED]   = 1'b1;
            ram_addr[PL_RED] = RAM_AW'({font_char, font_idx});
            font_idx_next    = font_idx + 1'b1;
            rd_src           = RS_RED;
          end else if (page_is_plane) begin
            ram_en[page_plane]         = 1'b1;
            plane_idx_next[page_plane] = plane_idx[page_plane] + 1'b1;
            case (page_plane)
              PL_BLUE:  rd_src = RS_BLUE;
              PL_GREEN: rd_src = RS_GREEN;
              default:  rd_src = RS_RED;
            endcase
          end else begin
            rd_src = RS_OFF_PAGE;
          end
        end
        FN_WRITE: begin
          if (page_is_plane) begin
            ram_en[page_plane]         = 1'b1;
            ram_we[page_plane]         = 1'b1;
            plane_idx_next[page_plane] = plane_idx[page_plane] + 1'b1;
          end
        end
        FN_SELECT: begin
          sel_char_next = data_byte;
          font_idx_next = '0;
          for (int p = 0; p < PLANES; p++) begin
            plane_idx_next[p] = '0;
          end
        end
        FN_LOAD_BYTE: begin
          if (load_ok && load_plane != 2'd3) begin
            ram_en[load_plane]   = 1'b1;
            ram_we[load_plane]   = 1'b1;
            ram_addr[load_plane] = RAM_AW'({load_char, load_row});
          end
        end
        FN_LOAD_ROW: begin
          if (load_ok) begin
            for (int p = 0; p < PLANES; p++) begin
              ram_en[p]   = 1'b1;
              ram_we[p]   = 1'b1;
              ram_addr[p] = RAM_AW'({load_char, load_row});
            end
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar p = 0; p < PLANES; p++) begin : g_plane
    cpp_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEPTH)
    ) u_ram (
      .clk  (clk),
      .en   (ram_en[p]),
      .we   (ram_we[p]),
      .addr (ram_addr[p]),
      .wdata(ram_wdata),
      .rdata(ram_q[p])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      sel_char   <= '0;
      font_idx   <= '0;
      for (int p = 0; p < PLANES; p++) begin
        plane_idx[p] <= '0;
      end
    end else begin
      if (clr_active) begin
        if (clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
          clr_active <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
      sel_char <= sel_char_next;
      font_idx <= font_idx_next;
      for (int p = 0; p < PLANES; p++) begin
        plane_idx[p] <= plane_idx_next[p];
      end
    end
  end

  // Read stage and output register. The read stage only moves on when it is
  // empty or the output register is free, so the RAM read data stays put while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (!s1_valid || out_free) begin
        s1_valid <= accept;
      end
      if (out_free) begin
        m_axis_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src <= rd_src;
      s1_win <= win;
    end
    if (out_free && s1_valid) begin
      m_axis_tuser <= s1_win;
      case (s1_src)
        RS_RED:      m_axis_tdata <= ram_q[PL_RED];
        RS_GREEN:    m_axis_tdata <= ram_q[PL_GREEN];
        RS_BLUE:     m_axis_tdata <= ram_q[PL_BLUE];
        RS_OFF_PAGE: m_axis_tdata <= OFF_PAGE_DATA;
        default:     m_axis_tdata <= '0;
      endcase
    end
  end

`ifndef SYNTHESIS
  // No request may enter while the memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !s_axis_tready)
    else $error("request accepted during clearing pass");

  // Nothing is in flight during the clearing pass.
  a_empty_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> (!s1_valid && !m_axis_tvalid))
    else $error("pipeline busy during clearing pass");

  // A select clears every row index.
  a_select_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FN_SELECT) |=>
      (font_idx == '0 && plane_idx[0] == '0 && plane_idx[1] == '0 &&
       plane_idx[2] == '0))
    else $error("row index not cleared by select");

  // A held read stage stays valid and keeps its source and window flag; no RAM read occurs while it waits.
  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_src) && $stable(s1_win)))
    else $error("read stage changed while stalled");
`endif

endmodule
